>>> rtl/sorted_key_list_unit_assert.svh
// ----------------------------------------------------------------------------
// sorted_key_list_unit_assert.svh
// Assertion macros for the sorted key list unit.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_LIST_UNIT_ASSERT_SVH
`define SORTED_KEY_LIST_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// Check a property on a given clock, disabled while the reset is applied.
`define SKLU_ASSERT_CLK(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check a property on the unit clock and reset.
`define SKLU_ASSERT(name, prop, msg) \
  `SKLU_ASSERT_CLK(name, clk_i, rst_ni, prop, msg)
`else
`define SKLU_ASSERT_CLK(name, clk, rst_n, prop, msg)
`define SKLU_ASSERT(name, prop, msg)
`endif

`endif

>>> rtl/sklu_pkg.sv
// ----------------------------------------------------------------------------
// sklu_pkg
// Types and codes shared by the sorted key list unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sklu_pkg;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned KEY_IN_W = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 10;

  // Request operation codes; any other code acts as a query
  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_QUERY  = 2'd2
  } sklu_op_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } sklu_status_e;

  // Sequencer states, one-hot
  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_READ   = 4'b0010,
    S_EVAL   = 4'b0100,
    S_FINISH = 4'b1000
  } sklu_state_e;

endpackage

>>> rtl/sklu_ram.sv
// ----------------------------------------------------------------------------
// sklu_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sklu_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write the addressed entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Register the read data
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/sorted_key_list_unit.sv
// ----------------------------------------------------------------------------
// sorted_key_list_unit
// Bounded list of keys kept in ascending order in one RAM.
// ----------------------------------------------------------------------------
// A request (operation, key) is taken when start is high and busy is low;
// exactly one result (status_o, found_o, count_o) follows, valid for the
// single cycle in which done_o is high. The result cannot be held off, so
// capture it on that cycle. A request walks the list from entry 0 through
// the single RAM read port; each entry is read, then compared and written
// back. A query, a failed delete or an insert into a full list stops at
// the first key not below the request key; an insert or a successful
// delete walks every stored key, moving the tail by one entry.
// The list is empty after reset with no clearing pass: unused entries are
// never read. The next request may start in the cycle done_o is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "sorted_key_list_unit_assert.svh"

module sorted_key_list_unit #(
  parameter int unsigned CAPACITY = 512,
  parameter int unsigned KEY_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [sklu_pkg::OP_W-1:0]       operation_i,
  input  logic [sklu_pkg::KEY_IN_W-1:0]   key_i,
  output logic                            done_o,
  output logic [sklu_pkg::STATUS_W-1:0]   status_o,
  output logic                            found_o,
  output logic [sklu_pkg::COUNT_W-1:0]    count_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  sklu_pkg::sklu_state_e  state_q, state_d;
  sklu_pkg::sklu_status_e res_status_q, res_status_d;

  logic [CW-1:0]       idx_q, idx_d, idx_prev;
  logic [CW-1:0]       count_q, count_d;
  logic [KEY_BITS-1:0] key_q, carry_q, carry_d;
  logic                shift_q, shift_d;
  logic                hit_q, hit_d;
  logic                ins_q, del_q, full_q;
  logic                done_q;
  logic                res_found_q, res_found_d;
  logic [sklu_pkg::COUNT_W-1:0] res_count_q, res_count_d;
  logic                accept;
  logic                list_full;

  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [KEY_BITS-1:0] mem_wdata;
  logic [KEY_BITS-1:0] mem_rdata;

  assign busy      = (state_q != sklu_pkg::S_IDLE);
  assign accept    = start && !busy;
  assign list_full = (count_q == CW'(CAPACITY));
  assign idx_prev  = idx_q - CW'(1);

  // Key storage
  sklu_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (mem_rdata)
  );

  // Sequence the scan, ripple the tail and build the result
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    count_d      = count_q;
    carry_d      = carry_q;
    shift_d      = shift_q;
    hit_d        = hit_q;
    res_status_d = res_status_q;
    res_found_d  = res_found_q;
    res_count_d  = res_count_q;
    mem_we       = 1'b0;
    mem_waddr    = idx_q[AW-1:0];
    mem_wdata    = carry_q;
    case (state_q)
      sklu_pkg::S_IDLE: begin
        if (start) begin
          idx_d   = '0;
          shift_d = 1'b0;
          hit_d   = 1'b0;
          state_d = sklu_pkg::S_READ;
        end
      end
      sklu_pkg::S_READ: begin
        // The read of entry idx is issued here; at the list end the scan goes to finish
        if (idx_q == count_q) begin
          state_d = sklu_pkg::S_FINISH;
        end else begin
          state_d = sklu_pkg::S_EVAL;
        end
      end
      sklu_pkg::S_EVAL: begin
        idx_d   = idx_q + CW'(1);
        state_d = sklu_pkg::S_READ;
        if (!shift_q) begin
          // Search for the first key not below the request key
          if (mem_rdata >= key_q) begin
            hit_d = (mem_rdata == key_q);
            if (ins_q) begin
              mem_we    = 1'b1;
              mem_wdata = key_q;
              carry_d   = mem_rdata;
              shift_d   = 1'b1;
            end else if (del_q && (mem_rdata == key_q)) begin
              shift_d = 1'b1;
            end else begin
              idx_d   = idx_q;
              state_d = sklu_pkg::S_FINISH;
            end
          end
        end else if (ins_q) begin
          // Move the carried key in and carry the old one up
          mem_we    = 1'b1;
          mem_wdata = carry_q;
          carry_d   = mem_rdata;
        end else begin
          // Move each later key down one entry
          mem_we    = 1'b1;
          mem_waddr = idx_prev[AW-1:0];
          mem_wdata = mem_rdata;
        end
      end
      sklu_pkg::S_FINISH: begin
        state_d      = sklu_pkg::S_IDLE;
        idx_d        = '0;
        res_found_d  = hit_q;
        res_status_d = sklu_pkg::ST_OK;
        if (ins_q) begin
          mem_we    = 1'b1;
          mem_waddr = count_q[AW-1:0];
          mem_wdata = shift_q ? carry_q : key_q;
          count_d   = count_q + CW'(1);
        end else if (full_q) begin
          res_status_d = sklu_pkg::ST_FULL;
        end else if (del_q) begin
          if (shift_q) begin
            count_d = count_q - CW'(1);
          end else begin
            res_status_d = sklu_pkg::ST_NOT_FOUND;
          end
        end
        res_count_d = sklu_pkg::COUNT_W'(count_d);
      end
      default: begin
        state_d = sklu_pkg::S_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sklu_pkg::S_IDLE;
      idx_q   <= '0;
      count_q <= '0;
      shift_q <= 1'b0;
      hit_q   <= 1'b0;
      ins_q   <= 1'b0;
      del_q   <= 1'b0;
      full_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      count_q <= count_d;
      shift_q <= shift_d;
      hit_q   <= hit_d;
      done_q  <= (state_q == sklu_pkg::S_FINISH);
      if (accept) begin
        ins_q  <= (sklu_pkg::sklu_op_e'(operation_i) == sklu_pkg::OP_INSERT) && !list_full;
        full_q <= (sklu_pkg::sklu_op_e'(operation_i) == sklu_pkg::OP_INSERT) && list_full;
        del_q  <= (sklu_pkg::sklu_op_e'(operation_i) == sklu_pkg::OP_DELETE);
      end
    end
  end

  // Hold the request key, the carried key and the result
  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q <= KEY_BITS'(key_i);
    end
    carry_q      <= carry_d;
    res_status_q <= res_status_d;
    res_found_q  <= res_found_d;
    res_count_q  <= res_count_d;
  end

  assign done_o   = done_q;
  assign status_o = res_status_q;
  assign found_o  = res_found_q;
  assign count_o  = res_count_q;

  `SKLU_ASSERT(a_count_bound, count_q <= CW'(CAPACITY), "key count exceeds capacity")
  `SKLU_ASSERT(a_idx_bound, idx_q <= count_q, "scan index beyond stored keys")
  `SKLU_ASSERT(a_write_busy, mem_we |-> busy, "RAM write outside a request")
  `SKLU_ASSERT(a_one_result, (state_q == sklu_pkg::S_FINISH) |=> done_o && !busy, "no result")
  `SKLU_ASSERT(a_excl_op, !(ins_q && (del_q || full_q)), "conflicting operation flags")

endmodule

>>> sim/sorted_key_list_unit_tb.sv
// ----------------------------------------------------------------------------
// sorted_key_list_unit_tb
// Self-checking bench for the sorted key list unit: a queue-fed driver issues
// insert, delete and query requests, a predictor keeps its own sorted copy of
// the list, and a monitor compares every result strobe with the prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_key_list_unit_tb;

  localparam int unsigned CAPACITY = 512;
  localparam int unsigned KEY_BITS = 16;
  localparam logic [sklu_pkg::KEY_IN_W-1:0] KEY_MASK =
    sklu_pkg::KEY_IN_W'((64'd1 << KEY_BITS) - 1);
  // Spare operation code, handled like a query
  localparam logic [sklu_pkg::OP_W-1:0] OP_SPARE = 2'd3;
  localparam int unsigned STALL_LIMIT = 10000;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [sklu_pkg::OP_W-1:0]     op;
    logic [sklu_pkg::KEY_IN_W-1:0] key;
  } request_t;

  typedef struct packed {
    logic [sklu_pkg::STATUS_W-1:0] status;
    logic                          found;
    logic [sklu_pkg::COUNT_W-1:0]  count;
  } outcome_t;

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          start       = 1'b0;
  logic [sklu_pkg::OP_W-1:0]     operation_i = '0;
  logic [sklu_pkg::KEY_IN_W-1:0] key_i       = '0;
  logic                          busy;
  logic                          done_o;
  logic [sklu_pkg::STATUS_W-1:0] status_o;
  logic                          found_o;
  logic [sklu_pkg::COUNT_W-1:0]  count_o;

  request_t                      request_q[$];
  outcome_t                      outcome_q[$];
  logic [sklu_pkg::KEY_IN_W-1:0] held_keys[$];
  int unsigned                   sender_idle_pct = 0;
  int unsigned                   error_count = 0;
  int unsigned                   stall_cycles = 0;

  // Predicted list contents
  logic [sklu_pkg::KEY_IN_W-1:0] list_keys [CAPACITY];
  int unsigned                   list_len = 0;

  sorted_key_list_unit #(
    .CAPACITY(CAPACITY),
    .KEY_BITS(KEY_BITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .operation_i(operation_i),
    .key_i      (key_i),
    .done_o     (done_o),
    .status_o   (status_o),
    .found_o    (found_o),
    .count_o    (count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Apply one request to the predicted list and queue the outcome
  task automatic apply_request(input logic [sklu_pkg::OP_W-1:0] op,
                               input logic [sklu_pkg::KEY_IN_W-1:0] key_in);
    logic [sklu_pkg::KEY_IN_W-1:0] k;
    int unsigned                   pos;
    logic                          present;
    outcome_t                      res;
    k = key_in & KEY_MASK;
    pos = 0;
    while (pos < list_len && list_keys[pos] < k) pos++;
    present = (pos < list_len) && (list_keys[pos] == k);
    res.status = sklu_pkg::ST_OK;
    if (op == sklu_pkg::OP_INSERT) begin
      if (list_len >= CAPACITY) begin
        res.status = sklu_pkg::ST_FULL;
      end else begin
        for (int unsigned i = list_len; i > pos; i--) list_keys[i] = list_keys[i-1];
        list_keys[pos] = k;
        list_len++;
      end
    end else if (op == sklu_pkg::OP_DELETE) begin
      if (!present) begin
        res.status = sklu_pkg::ST_NOT_FOUND;
      end else begin
        for (int unsigned i = pos; i + 1 < list_len; i++) list_keys[i] = list_keys[i+1];
        list_len--;
      end
    end
    res.found = present;
    res.count = sklu_pkg::COUNT_W'(list_len);
    outcome_q = {outcome_q, res};
  endtask

  task automatic note_mismatch(input string what, input int unsigned exp_v,
                               input int unsigned act_v);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("[%0t] MISMATCH %s: expected %0d, got %0d", $realtime, what, exp_v, act_v);
  endtask

  // Queue a request for the driver; track stored keys to aim deletes and queries
  task automatic queue_request(input logic [sklu_pkg::OP_W-1:0] op,
                               input logic [sklu_pkg::KEY_IN_W-1:0] key);
    request_t r;
    int       hits[$];
    r.op = op;
    r.key = key;
    request_q = {request_q, r};
    if (op == sklu_pkg::OP_INSERT) begin
      if (held_keys.size() < CAPACITY) held_keys = {held_keys, key};
    end else if (op == sklu_pkg::OP_DELETE) begin
      hits = held_keys.find_first_index(x) with (x == key);
      if (hits.size() > 0) held_keys.delete(hits[0]);
    end
  endtask

  function automatic logic [sklu_pkg::KEY_IN_W-1:0] pick_key(input int unsigned key_max,
                                                             input int unsigned stored_pct);
    if (held_keys.size() > 0 && $urandom_range(99) < stored_pct)
      return held_keys[$urandom_range(held_keys.size() - 1)];
    if ($urandom_range(9) == 0) return sklu_pkg::KEY_IN_W'($urandom_range(65535));
    return sklu_pkg::KEY_IN_W'($urandom_range(key_max));
  endfunction

  // Random requests that steer the list length toward a target
  task automatic random_mix(input int unsigned n, input int unsigned target,
                            input int unsigned key_max);
    int unsigned roll;
    int unsigned ins_pct;
    for (int unsigned i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      ins_pct = (held_keys.size() < target) ? 55 : 25;
      if (roll < ins_pct)
        queue_request(sklu_pkg::OP_INSERT, pick_key(key_max, 0));
      else if (roll < ins_pct + 20 + (held_keys.size() < target ? 0 : 30))
        queue_request(sklu_pkg::OP_DELETE, pick_key(key_max, 80));
      else if (roll < 94)
        queue_request(sklu_pkg::OP_QUERY, pick_key(key_max, 50));
      else
        queue_request(OP_SPARE, pick_key(key_max, 50));
    end
  endtask

  task automatic wait_drained();
    while (request_q.size() > 0 || outcome_q.size() > 0 || start) @(posedge clk_i);
  endtask

  // Driver: record each transfer, hold a pending request, launch the next one
  always @(posedge clk_i or negedge rst_ni) begin : driver
    request_t nxt;
    if (!rst_ni) begin
      start       <= 1'b0;
      operation_i <= '0;
      key_i       <= '0;
    end else begin
      if (start && !busy) apply_request(operation_i, key_i);
      if (!start || !busy) begin
        if (request_q.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          nxt = request_q.pop_front();
          start       <= 1'b1;
          operation_i <= nxt.op;
          key_i       <= nxt.key;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result strobe with the oldest prediction
  always @(posedge clk_i) begin : monitor
    outcome_t exp_r;
    if (rst_ni && done_o) begin
      if (outcome_q.size() == 0) begin
        note_mismatch("result with no request pending", 0, 1);
      end else begin
        exp_r = outcome_q.pop_front();
        if (status_o !== exp_r.status) note_mismatch("status", exp_r.status, status_o);
        if (found_o !== exp_r.found) note_mismatch("found", exp_r.found, found_o);
        if (count_o !== exp_r.count) note_mismatch("count", exp_r.count, count_o);
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty list, extreme keys, duplicates, every operation code
    sender_idle_pct = 12;
    queue_request(sklu_pkg::OP_QUERY, 16'h0000);
    queue_request(sklu_pkg::OP_DELETE, 16'hFFFF);
    queue_request(OP_SPARE, 16'h0000);
    queue_request(sklu_pkg::OP_INSERT, 16'h8000);
    queue_request(sklu_pkg::OP_INSERT, 16'h0000);
    queue_request(sklu_pkg::OP_INSERT, 16'hFFFF);
    queue_request(sklu_pkg::OP_INSERT, 16'h8000);
    queue_request(sklu_pkg::OP_INSERT, 16'h7FFF);
    queue_request(sklu_pkg::OP_QUERY, 16'h8000);
    queue_request(sklu_pkg::OP_QUERY, 16'h1234);
    queue_request(OP_SPARE, 16'hFFFF);
    queue_request(sklu_pkg::OP_DELETE, 16'h8000);
    queue_request(sklu_pkg::OP_QUERY, 16'h8000);
    queue_request(sklu_pkg::OP_DELETE, 16'h8000);
    queue_request(sklu_pkg::OP_DELETE, 16'h8000);
    queue_request(sklu_pkg::OP_DELETE, 16'h0000);
    queue_request(sklu_pkg::OP_DELETE, 16'hFFFF);
    queue_request(sklu_pkg::OP_DELETE, 16'h7FFF);
    queue_request(sklu_pkg::OP_INSERT, 16'h5555);
    queue_request(sklu_pkg::OP_INSERT, 16'hAAAA);
    queue_request(sklu_pkg::OP_DELETE, 16'h5555);
    queue_request(sklu_pkg::OP_DELETE, 16'hAAAA);

    // Short lists with narrow keys to force duplicates
    random_mix(60, 24, 63);
    wait_drained();

    // Sparse sender, wide keys
    sender_idle_pct = 64;
    random_mix(40, 12, 65535);
    wait_drained();

    // Back to back: fill the list to capacity, then work at the full mark
    sender_idle_pct = 0;
    while (held_keys.size() < CAPACITY)
      queue_request(sklu_pkg::OP_INSERT, pick_key(1023, 0));
    queue_request(sklu_pkg::OP_INSERT, 16'hFFFF);
    queue_request(sklu_pkg::OP_INSERT, held_keys[0]);
    queue_request(OP_SPARE, held_keys[1]);
    random_mix(24, CAPACITY, 1023);
    wait_drained();

    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> sorted_key_list_unit.f
+incdir+rtl
rtl/sklu_pkg.sv
rtl/sklu_ram.sv
rtl/sorted_key_list_unit.sv
sim/sorted_key_list_unit_tb.sv
